// ===== design/ssrt_pkg.sv =====
`timescale 1ns / 1ps

package ssrt_pkg;

  localparam int unsigned ScoreW = 10;
  localparam int unsigned TagW   = 8;

  typedef struct packed {
    logic [ScoreW-1:0] score_first;
    logic [ScoreW-1:0] score_second;
    logic [TagW-1:0]   record_tag;
    logic              end_of_batch;
  } in_word_t;

  typedef struct packed {
    logic [ScoreW-1:0] sorted_first;
    logic [ScoreW-1:0] sorted_second;
    logic [TagW-1:0]   sorted_tag;
    logic              last_of_run;
    logic              dropped_any;
  } out_word_t;

  typedef struct packed {
    logic [ScoreW-1:0] first;
    logic [ScoreW-1:0] second;
    logic [TagW-1:0]   tag;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

  // True when record a must stand strictly ahead of record b.
  function automatic logic rec_less(input rec_t a, input rec_t b);
    logic [ScoreW:0] sum_a;
    logic [ScoreW:0] sum_b;
    logic            res;
    sum_a = {1'b0, a.first} + {1'b0, a.second};
    sum_b = {1'b0, b.first} + {1'b0, b.second};
    if (sum_a != sum_b) begin
      res = (sum_a < sum_b);
    end else if (a.first != b.first) begin
      res = (a.first < b.first);
    end else begin
      res = (a.second < b.second);
    end
    return res;
  endfunction

endpackage

// ===== design/ssrt_cell.sv =====
`timescale 1ns / 1ps

module ssrt_cell import ssrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_rec_i,
  input  rec_t       prev_rec_i,
  input  logic       prev_valid_i,
  input  logic       prev_shift_i,
  input  rec_t       next_rec_i,
  input  logic       next_valid_i,
  output rec_t       rec_o,
  output logic       valid_o,
  output logic       shift_o
);

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;

  assign shift_o = valid_q && rec_less(new_rec_i, rec_q);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.pop) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert) begin
      if (shift_o || (!valid_q && prev_valid_i)) begin
        valid_d = 1'b1;
        rec_d   = prev_shift_i ? prev_rec_i : new_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

// ===== design/stable_two_key_record_sorter.sv =====
`timescale 1ns / 1ps

// Stable insertion sorter for one batch of records.
// Input channel: in_valid_i, in_stall_o and in_word_i. A word is taken at a rising
// edge with in_valid_i high and in_stall_o low. Each record is placed in a row of
// DEPTH cells as it is taken, one record per cycle while in_stall_o is low.
// Order is by score sum, then first score, then second score; equal records keep
// their arrival order. A record that arrives while all cells are full is dropped.
// The word marked end of batch is stored like any other and starts the drain:
// from the next cycle the sorted records leave on out_word_o, one per cycle that
// out_stall_i is low, taken from the head cell while the row shifts towards it.
// The final word carries last_of_run, and every word of a batch that lost records
// carries dropped_any. in_stall_o is high for the whole drain, which lasts until the
// final word is taken by the receiver.
// When out_stall_i is high the output word holds and the row does not move.
// Reset empties all cells and clears the drop flag; no output is pending after it.
module stable_two_key_record_sorter import ssrt_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  rec_t       rec_w     [DEPTH];
  logic       valid_w   [DEPTH];
  logic       shift_w   [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  rec_t       new_rec;
  cell_ctrl_t ctrl;
  logic       drain_q, drain_d;
  logic       overflow_q, overflow_d;
  logic       in_acc, out_acc, full, last_word;

  assign new_rec.first  = in_word_i.score_first;
  assign new_rec.second = in_word_i.score_second;
  assign new_rec.tag    = in_word_i.record_tag;

  assign in_stall_o = drain_q;
  assign in_acc     = in_valid_i && !drain_q;
  assign full       = valid_w[DEPTH-1];
  assign out_valid_o = drain_q && valid_w[0];
  assign out_acc    = out_valid_o && !out_stall_i;
  assign last_word  = !valid_w[1];

  assign ctrl.insert = in_acc && !full;
  assign ctrl.pop    = out_acc;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_valid, prev_shift, next_valid;
    if (i == 0) begin : g_head
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b1;
      assign prev_shift = 1'b0;
    end else begin : g_body
      assign prev_rec   = rec_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_shift = shift_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_rec   = rec_w[i];
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_rec   = rec_w[i+1];
      assign next_valid = valid_w[i+1];
    end
    ssrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .prev_rec_i   (prev_rec),
      .prev_valid_i (prev_valid),
      .prev_shift_i (prev_shift),
      .next_rec_i   (next_rec),
      .next_valid_i (next_valid),
      .rec_o        (rec_w[i]),
      .valid_o      (valid_w[i]),
      .shift_o      (shift_w[i])
    );
    assign valid_vec[i] = valid_w[i];
  end

  always_comb begin
    drain_d    = drain_q;
    overflow_d = overflow_q;
    if (in_acc) begin
      if (full) begin
        overflow_d = 1'b1;
      end
      if (in_word_i.end_of_batch) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc && last_word) begin
      drain_d    = 1'b0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q    <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      drain_q    <= drain_d;
      overflow_q <= overflow_d;
    end
  end

  assign out_word_o.sorted_first  = rec_w[0].first;
  assign out_word_o.sorted_second = rec_w[0].second;
  assign out_word_o.sorted_tag    = rec_w[0].tag;
  assign out_word_o.last_of_run   = last_word;
  assign out_word_o.dropped_any   = overflow_q;

  a_drain_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> valid_w[0])
    else $error("drain running with an empty head cell");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word) |=> (!drain_q && valid_vec == '0 && !overflow_q))
    else $error("store not empty after the final word");

  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_word) |=> out_valid_o)
    else $error("drain stopped before the final word");

endmodule

// ===== verif/tb_stable_two_key_record_sorter.sv =====
`timescale 1ns / 1ps

module tb_stable_two_key_record_sorter;
  import ssrt_pkg::*;

  localparam int unsigned Depth = 32;
  localparam logic Mid = 1'b0;
  localparam logic Eob = 1'b1;
  localparam int NumDirected = 16;
  localparam int NumItems = 100;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  rec_t      sorted_recs[$];
  bit        batch_lost;
  out_word_t pending_words[$];
  bit        in_burst;
  bit        out_burst;
  int        fail_count;
  int        words_checked;
  int        records_sent;
  int        batches_sent;
  int        lossy_batches;

  // Single-record batches have their result typed in; the rest are predicted.
  stim_row_t directed_rows [NumDirected] = '{
    '{'{10'd0,    10'd0,    8'h00, Eob}, 1'b1, '{10'd0,    10'd0,    8'h00, 1'b1, 1'b0}},
    '{'{10'd1023, 10'd1023, 8'hff, Eob}, 1'b1, '{10'd1023, 10'd1023, 8'hff, 1'b1, 1'b0}},
    '{'{10'd1023, 10'd0,    8'haa, Eob}, 1'b1, '{10'd1023, 10'd0,    8'haa, 1'b1, 1'b0}},
    '{'{10'd5,    10'd5,    8'h10, Mid}, 1'b0, '0},
    '{'{10'd3,    10'd7,    8'h11, Mid}, 1'b0, '0},
    '{'{10'd5,    10'd5,    8'h12, Mid}, 1'b0, '0},
    '{'{10'd10,   10'd0,    8'h13, Mid}, 1'b0, '0},
    '{'{10'd0,    10'd0,    8'h14, Mid}, 1'b0, '0},
    '{'{10'd1023, 10'd1023, 8'h15, Mid}, 1'b0, '0},
    '{'{10'd7,    10'd3,    8'h16, Mid}, 1'b0, '0},
    '{'{10'd5,    10'd5,    8'h17, Mid}, 1'b0, '0},
    '{'{10'd0,    10'd10,   8'h18, Eob}, 1'b0, '0},
    '{'{10'h2aa,  10'h155,  8'h55, Mid}, 1'b0, '0},
    '{'{10'h155,  10'h2aa,  8'haa, Eob}, 1'b0, '0},
    '{'{10'd1,    10'd2,    8'h01, Mid}, 1'b0, '0},
    '{'{10'd1,    10'd2,    8'h02, Eob}, 1'b0, '0}
  };

  stable_two_key_record_sorter #(.DEPTH(Depth)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [30:0] order_key(input rec_t r);
    return {({1'b0, r.first} + {1'b0, r.second}), r.first, r.second};
  endfunction

  function automatic void sort_record(input in_word_t w, ref out_word_t outs[$]);
    rec_t      r;
    int        j;
    out_word_t o;
    r.first  = w.score_first;
    r.second = w.score_second;
    r.tag    = w.record_tag;
    outs.delete();
    if (sorted_recs.size() < Depth) begin
      j = sorted_recs.size();
      while (j > 0 && order_key(r) < order_key(sorted_recs[j-1])) j--;
      sorted_recs.insert(j, r);
    end else begin
      batch_lost = 1'b1;
    end
    if (w.end_of_batch) begin
      foreach (sorted_recs[k]) begin
        o.sorted_first  = sorted_recs[k].first;
        o.sorted_second = sorted_recs[k].second;
        o.sorted_tag    = sorted_recs[k].tag;
        o.last_of_run   = (k == sorted_recs.size() - 1);
        o.dropped_any   = batch_lost;
        outs.insert(outs.size(), o);
      end
      sorted_recs.delete();
      batch_lost = 1'b0;
    end
  endfunction

  function automatic in_word_t random_record(input bit last);
    in_word_t w;
    if ($urandom_range(0, 2) == 0) begin
      w.score_first  = 10'($urandom_range(0, 3));
      w.score_second = 10'($urandom_range(0, 3));
    end else begin
      w.score_first  = 10'($urandom_range(0, 1023));
      w.score_second = 10'($urandom_range(0, 1023));
    end
    w.record_tag   = 8'($urandom_range(0, 255));
    w.end_of_batch = last;
    return w;
  endfunction

  // Called and left at a falling edge; the valid stays high for a following word.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_word);
    int        gap;
    out_word_t outs[$];
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sort_record(w, outs);
    if (typed) begin
      pending_words.insert(pending_words.size(), typed_word);
    end else begin
      foreach (outs[k]) pending_words.insert(pending_words.size(), outs[k]);
    end
    records_sent++;
    if (w.end_of_batch) begin
      batches_sent++;
      if (outs.size() > 0 && outs[0].dropped_any) lossy_batches++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) begin
      send_word(random_record(i == len - 1), 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_word(input out_word_t exp);
    words_checked++;
    if (out_word_o.sorted_first !== exp.sorted_first) begin
      $error("sorted_first: expected %0d, got %0d", exp.sorted_first, out_word_o.sorted_first);
      fail_count++;
    end
    if (out_word_o.sorted_second !== exp.sorted_second) begin
      $error("sorted_second: expected %0d, got %0d", exp.sorted_second,
             out_word_o.sorted_second);
      fail_count++;
    end
    if (out_word_o.sorted_tag !== exp.sorted_tag) begin
      $error("sorted_tag: expected %0d, got %0d", exp.sorted_tag, out_word_o.sorted_tag);
      fail_count++;
    end
    if (out_word_o.last_of_run !== exp.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", exp.last_of_run, out_word_o.last_of_run);
      fail_count++;
    end
    if (out_word_o.dropped_any !== exp.dropped_any) begin
      $error("dropped_any: expected %0d, got %0d", exp.dropped_any, out_word_o.dropped_any);
      fail_count++;
    end
  endtask

  initial begin
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = out_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_words.size() == 0) begin
        $error("unexpected sorted word %h", out_word_o);
        fail_count++;
      end else begin
        check_word(pending_words.pop_front());
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    batch_lost = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
    end
    wait_drained();

    // A batch that exactly fills the store, then one whose closing word is lost.
    send_batch(Depth);
    send_batch(Depth + 1);
    while (records_sent < NumItems) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0 && records_sent + Depth + 4 <= NumItems) begin
        send_batch($urandom_range(Depth - 2, Depth + 4));
      end else begin
        send_batch($urandom_range(1, 8));
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
    repeat (2 * Depth) @(negedge clk_i);

    $display("tb: %0d records in %0d batches, %0d of them over capacity", records_sent,
             batches_sent, lossy_batches);
    $display("tb: %0d sorted words compared", words_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/ssrt_pkg.sv
design/ssrt_cell.sv
design/stable_two_key_record_sorter.sv
verif/tb_stable_two_key_record_sorter.sv
